### rtl/dtcd_pkg.sv
// ----------------------------------------------------------------------------
// dtcd_pkg
// Shared types and constants for the dshot telemetry capture and decode block.
// ----------------------------------------------------------------------------
package dtcd_pkg;

   localparam int MOTORS_DEF   = 4;
   localparam int PULSES_DEF   = 20;
   localparam int WIDTH_BITS   = 16;
   localparam int FRAME_BITS   = 16;
   localparam int NIBBLE_BITS  = 4;

   localparam logic [2:0] MOTOR_COUNT_RESET = 3'd4;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [3:0] EXT_TEMP = 4'h2;
   localparam logic [3:0] EXT_VOLT = 4'h4;
   localparam logic [3:0] EXT_CURR = 4'h6;

   localparam logic [6:0] ERPM_SCALE = 7'd100;
   localparam logic [7:0] VOLT_SCALE = 8'd250;
   localparam logic [9:0] CURR_SCALE = 10'd1000;

   typedef enum logic [2:0] {
      STAT_BAD_INDEX = 3'd0,
      STAT_NOT_READY = 3'd1,
      STAT_CRC_FAIL  = 3'd2,
      STAT_ERPM      = 3'd3,
      STAT_EXTENDED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_DECODE
   } ctl_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_LOAD,
      SC_MAX,
      SC_MIN,
      SC_THR,
      SC_BITS
   } scan_state_type;

   typedef struct packed {
      logic        op;
      logic [1:0]  motor;
      logic [31:0] edge_time_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] payload;
      logic [18:0] erpm;
      logic [15:0] voltage_mv;
      logic [7:0]  temperature_c;
      logic [17:0] current_ma;
   } rsp_type;

   typedef struct packed {
      logic                  done;
      logic [FRAME_BITS-1:0] frame;
   } scan_stat_type;

endpackage

### rtl/dtcd_width_mem.sv
// ----------------------------------------------------------------------------
// dtcd_width_mem
// Pulse width store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dtcd_width_mem #(
   parameter int DEPTH = dtcd_pkg::MOTORS_DEF * dtcd_pkg::PULSES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [dtcd_pkg::WIDTH_BITS-1:0] wr_data,
   input  logic [AW-1:0]                   rd_addr,
   output logic [dtcd_pkg::WIDTH_BITS-1:0] rd_data
);
   import dtcd_pkg::*;

   logic [WIDTH_BITS-1:0] mem_ff [DEPTH];
   logic [WIDTH_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dtcd_scan.sv
// ----------------------------------------------------------------------------
// dtcd_scan
// Walks one channel's stored widths with a single shared comparator: a
// min/max pass, then a threshold pass that slices the frame bits.
// ----------------------------------------------------------------------------
module dtcd_scan #(
   parameter int PULSES = dtcd_pkg::PULSES_DEF,
   parameter int IW     = $clog2(PULSES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [dtcd_pkg::WIDTH_BITS-1:0] rd_data,
   output logic [IW-1:0]                   rd_idx,
   output dtcd_pkg::scan_stat_type         stat
);
   import dtcd_pkg::*;

   localparam int              BW       = $clog2(FRAME_BITS);
   localparam logic [IW-1:0]   LAST_IDX = IW'(PULSES - 1);
   localparam logic [BW-1:0]   LAST_BIT = BW'(FRAME_BITS - 1);

   scan_state_type          state_ff, state_in;
   logic                    done_ff, done_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [BW-1:0]           bit_ff, bit_in;
   logic [WIDTH_BITS-1:0]   min_ff, min_in;
   logic [WIDTH_BITS-1:0]   max_ff, max_in;
   logic [WIDTH_BITS-1:0]   thr_ff, thr_in;
   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic [WIDTH_BITS-1:0]   cmp_a;
   logic [WIDTH_BITS-1:0]   cmp_b;
   logic                    cmp_gt;
   logic [WIDTH_BITS:0]     mid_sum;

   // shared comparator
   assign cmp_gt  = cmp_a > cmp_b;
   assign mid_sum = {1'b0, min_ff} + {1'b0, max_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      idx_in   = idx_ff;
      bit_in   = bit_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      thr_in   = thr_ff;
      frame_in = frame_ff;
      cmp_a    = rd_data;
      cmp_b    = thr_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (go) begin
               state_in = SC_LOAD;
               idx_in   = '0;
               bit_in   = '0;
               min_in   = '1;
               max_in   = '0;
            end
         end
         SC_LOAD: begin
            state_in = SC_MAX;
         end
         SC_MAX: begin
            cmp_a = rd_data;
            cmp_b = max_ff;
            if (cmp_gt) begin
               max_in = rd_data;
            end
            idx_in   = (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
            state_in = SC_MIN;
         end
         SC_MIN: begin
            cmp_a = min_ff;
            cmp_b = rd_data;
            if (cmp_gt) begin
               min_in = rd_data;
            end
            // index wraps to zero only after the last width
            state_in = (idx_ff == '0) ? SC_THR : SC_MAX;
         end
         SC_THR: begin
            thr_in   = mid_sum[WIDTH_BITS:1];
            idx_in   = idx_ff + IW'(1);
            state_in = SC_BITS;
         end
         SC_BITS: begin
            cmp_a    = rd_data;
            cmp_b    = thr_ff;
            frame_in = {frame_ff[FRAME_BITS-2:0], cmp_gt};
            idx_in   = idx_ff + IW'(1);
            bit_in   = bit_ff + BW'(1);
            if (bit_ff == LAST_BIT) begin
               state_in = SC_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      thr_ff   <= thr_in;
      frame_ff <= frame_in;
   end

   assign rd_idx     = idx_ff;
   assign stat.done  = done_ff;
   assign stat.frame = frame_ff;

endmodule

### rtl/dshot_telemetry_capture_decoder.sv
// ----------------------------------------------------------------------------
// dshot_telemetry_capture_decoder
// Captures bidirectional dshot telemetry pulse widths per motor channel and
// decodes a ready packet into eRPM or extended telemetry on request.
//
// Usage:
//   A request word is taken when start is high and busy is low. An edge word
//   stores the time since the channel's previous edge and gives no result.
//   A read word gives exactly one result word, marked by rsp_strobe for one
//   cycle; the receiver cannot stall it.
//   A read of an unused channel or of a channel whose packet is not ready
//   answers in the cycle after it is taken, and busy stays low.
//   A read of a ready packet holds busy while the scan unit runs and answers
//   once the decode state has formed the result. One scan comparator walks
//   the stored widths, each for max and then for min, then once per frame
//   bit, through the single read port of the width memory. csr_wdata sets
//   the number of channels in use; the user must write it only while idle,
//   as the block does not enforce this. Reset clears the channel timestamps,
//   counts and ready flags, sets four channels in use and leaves the width
//   memory as it is.
// ----------------------------------------------------------------------------
module dshot_telemetry_capture_decoder #(
   parameter int MOTORS            = dtcd_pkg::MOTORS_DEF,
   parameter int PULSES_PER_PACKET = dtcd_pkg::PULSES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dtcd_pkg::req_type req_word,
   output logic              rsp_strobe,
   output dtcd_pkg::rsp_type rsp_word,
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata
);
   import dtcd_pkg::*;

   localparam int IW    = $clog2(PULSES_PER_PACKET);
   localparam int CW    = $clog2(PULSES_PER_PACKET + 1);
   localparam int MIW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int DEPTH = MOTORS * PULSES_PER_PACKET;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0]    MOTORS_LIM = 4'(MOTORS);
   localparam logic [CW-1:0] FULL_CNT   = CW'(PULSES_PER_PACKET);
   localparam logic [AW-1:0] ROW_SIZE   = AW'(PULSES_PER_PACKET);

   ctl_state_type   ctl_state_ff, ctl_state_in;
   logic [2:0]      motor_count_ff;
   logic [31:0]     last_edge_ff [MOTORS];
   logic [CW-1:0]   count_ff [MOTORS];
   logic            ready_ff [MOTORS];
   logic [MIW-1:0]  sel_ff, sel_in;
   rsp_type         rsp_word_ff, rsp_word_in;
   logic            rsp_strobe_ff, rsp_strobe_in;

   logic            accept;
   logic [MIW-1:0]  m_idx;
   logic            in_use;
   logic [CW-1:0]   cur_count;
   logic [CW-1:0]   next_count;
   logic [31:0]     diff;
   logic            edge_go;
   logic            edge_store;
   logic            read_go;
   logic            scan_go;

   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [WIDTH_BITS-1:0]   rd_data;
   logic [IW-1:0]           scan_idx;
   scan_stat_type           scan_stat;

   logic [11:0]             data;
   logic [3:0]              crc;
   logic [7:0]              val;
   rsp_type                 dec_word;

   assign busy       = (ctl_state_ff != CTL_IDLE);
   assign accept     = start && !busy;
   assign m_idx      = MIW'(req_word.motor);
   assign in_use     = ({2'b00, req_word.motor} < MOTORS_LIM) &&
                       ({1'b0, req_word.motor} < motor_count_ff);
   assign cur_count  = count_ff[m_idx];
   assign next_count = cur_count + CW'(1);
   assign diff       = req_word.edge_time_us - last_edge_ff[m_idx];
   assign edge_go    = accept && (req_word.op == OP_EDGE) && in_use;
   assign edge_store = edge_go && (cur_count < FULL_CNT);
   assign read_go    = accept && (req_word.op == OP_READ) && in_use && ready_ff[m_idx];

   assign wr_addr = AW'(m_idx) * ROW_SIZE + AW'(cur_count[IW-1:0]);
   assign rd_addr = AW'(sel_ff) * ROW_SIZE + AW'(scan_idx);

   dtcd_width_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (edge_store),
      .wr_addr (wr_addr),
      .wr_data (diff[WIDTH_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dtcd_scan #(
      .PULSES (PULSES_PER_PACKET),
      .IW     (IW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .go      (scan_go),
      .rd_data (rd_data),
      .rd_idx  (scan_idx),
      .stat    (scan_stat)
   );

   // frame decode
   assign data = scan_stat.frame[FRAME_BITS-1:NIBBLE_BITS];
   assign crc  = data[3:0] ^ data[7:4] ^ data[11:8];
   assign val  = data[7:0];

   always_comb begin
      dec_word = '0;
      if (crc != scan_stat.frame[3:0]) begin
         dec_word.status = STAT_CRC_FAIL;
      end else begin
         dec_word.payload = data;
         if (!data[8] && (data[11:8] != 4'h0)) begin
            dec_word.status = STAT_EXTENDED;
            case (data[11:8])
               EXT_TEMP: begin
                  dec_word.temperature_c = val;
               end
               EXT_VOLT: begin
                  dec_word.voltage_mv = 16'(val) * 16'(VOLT_SCALE);
               end
               EXT_CURR: begin
                  dec_word.current_ma = 18'(val) * 18'(CURR_SCALE);
               end
               default: begin
               end
            endcase
         end else begin
            dec_word.status = STAT_ERPM;
            dec_word.erpm   = 19'(data) * 19'(ERPM_SCALE);
         end
      end
   end

   always_comb begin
      ctl_state_in  = ctl_state_ff;
      sel_in        = sel_ff;
      rsp_word_in   = '0;
      rsp_strobe_in = 1'b0;
      scan_go       = 1'b0;
      unique case (ctl_state_ff)
         CTL_IDLE: begin
            if (accept && (req_word.op == OP_READ)) begin
               if (!in_use) begin
                  rsp_word_in.status = STAT_BAD_INDEX;
                  rsp_strobe_in      = 1'b1;
               end else if (!ready_ff[m_idx]) begin
                  rsp_word_in.status = STAT_NOT_READY;
                  rsp_strobe_in      = 1'b1;
               end else begin
                  sel_in       = m_idx;
                  scan_go      = 1'b1;
                  ctl_state_in = CTL_SCAN;
               end
            end
         end
         CTL_SCAN: begin
            if (scan_stat.done) begin
               ctl_state_in = CTL_DECODE;
            end
         end
         CTL_DECODE: begin
            rsp_word_in   = dec_word;
            rsp_strobe_in = 1'b1;
            ctl_state_in  = CTL_IDLE;
         end
         default: begin
            ctl_state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CTL_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         ctl_state_ff  <= ctl_state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      rsp_word_ff <= rsp_word_in;
   end

   // per channel capture state
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_count_ff <= MOTOR_COUNT_RESET;
         for (int i = 0; i < MOTORS; i++) begin
            last_edge_ff[i] <= '0;
            count_ff[i]     <= '0;
            ready_ff[i]     <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            motor_count_ff <= csr_wdata;
         end
         if (edge_go) begin
            last_edge_ff[m_idx] <= req_word.edge_time_us;
         end
         if (edge_store) begin
            count_ff[m_idx] <= next_count;
            if (next_count == FULL_CNT) begin
               ready_ff[m_idx] <= 1'b1;
            end
         end
         if (read_go) begin
            count_ff[m_idx] <= '0;
            ready_ff[m_idx] <= 1'b0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

### rtl/dtcd_checker.sv
// ----------------------------------------------------------------------------
// dtcd_checker
// Port level checks for the telemetry capture and decode block.
// ----------------------------------------------------------------------------
module dtcd_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input dtcd_pkg::req_type req_word,
   input logic              rsp_strobe,
   input dtcd_pkg::rsp_type rsp_word
);
   import dtcd_pkg::*;

   // a taken read either answers at once or holds busy
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.op == OP_READ)) |=> (rsp_strobe || busy))
      else $error("read word neither answered nor busy");

   // an edge word never produces a result word
   a_edge_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.op == OP_EDGE)) |=> !rsp_strobe)
      else $error("result word after edge word");

   // end of a decode always delivers its word
   a_decode_delivers: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without result word");

   // only decoded frames carry data
   a_zero_on_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status != STAT_ERPM) && (rsp_word.status != STAT_EXTENDED))
      |-> ((rsp_word.payload == '0) && (rsp_word.erpm == '0) &&
           (rsp_word.voltage_mv == '0) && (rsp_word.temperature_c == '0) &&
           (rsp_word.current_ma == '0)))
      else $error("data fields set on status without frame");

endmodule

bind dshot_telemetry_capture_decoder dtcd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
